// ----- hdl/spa_pkg.sv -----
package spa_pkg;

  localparam int OPW   = 2;
  localparam int LENW  = 13;
  localparam int SLOTW = 9;
  localparam int STW   = 2;
  localparam int OFFW  = 13;
  localparam int FREEW = 13;
  localparam int USEDW = 10;

  typedef enum logic [OPW-1:0] {
    OP_RESET  = 2'd0,
    OP_INSERT = 2'd1,
    OP_GET    = 2'd2,
    OP_DELETE = 2'd3
  } opcode_t;

  typedef enum logic [STW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_DELETED = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, start slot table read
    logic commit;  // evaluate, update page state, load result register
  } spa_cmd_t;

endpackage

// ----- hdl/spa_if.sv -----
interface spa_req_if;
  import spa_pkg::*;
  logic             valid;
  logic             ready;
  logic [OPW-1:0]   opcode;
  logic [LENW-1:0]  tuple_length;
  logic [SLOTW-1:0] slot_number;

  modport source (output valid, output opcode, output tuple_length, output slot_number,
                  input ready);
  modport sink   (input valid, input opcode, input tuple_length, input slot_number,
                  output ready);
endinterface

interface spa_rsp_if;
  import spa_pkg::*;
  logic             valid;
  logic             ready;
  logic [STW-1:0]   status;
  logic [SLOTW-1:0] slot_index;
  logic [OFFW-1:0]  tuple_offset;
  logic [LENW-1:0]  tuple_bytes;
  logic [FREEW-1:0] free_bytes;
  logic [USEDW-1:0] slots_used;

  modport source (output valid, output status, output slot_index, output tuple_offset,
                  output tuple_bytes, output free_bytes, output slots_used,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input tuple_offset,
                  input tuple_bytes, input free_bytes, input slots_used,
                  output ready);
endinterface

// ----- hdl/spa_ctrl.sv -----
module spa_ctrl import spa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output spa_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;
  assign out_free  = !out_valid || rsp_ready;

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.commit     = 1'b0;
    out_valid_next = out_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the new result
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hdl/spa_datapath.sv -----
module spa_datapath import spa_pkg::*; #(
  parameter int PAGE_BYTES       = 4096,
  parameter int SLOT_ENTRY_BYTES = 8,
  parameter int HEADER_BYTES     = 16,
  parameter int MAX_SLOTS        = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  spa_cmd_t         cmd,
  input  logic [OPW-1:0]   opcode,
  input  logic [LENW-1:0]  tuple_length,
  input  logic [SLOTW-1:0] slot_number,
  output logic [STW-1:0]   status,
  output logic [SLOTW-1:0] slot_index,
  output logic [OFFW-1:0]  tuple_offset,
  output logic [LENW-1:0]  tuple_bytes,
  output logic [FREEW-1:0] free_bytes,
  output logic [USEDW-1:0] slots_used
);

  localparam int PW   = $clog2(PAGE_BYTES + 1);
  localparam int CNTW = $clog2(MAX_SLOTS + 1);
  localparam int IW   = $clog2(MAX_SLOTS);
  localparam int NW   = LENW + 1;
  localparam int CW   = (PW > NW) ? PW : NW;
  localparam int SW   = (IW > SLOTW) ? IW : SLOTW;
  localparam int KW   = (CNTW > SW) ? CNTW : SW;
  localparam int EW   = PW + LENW + 1;
  localparam int FS0  = (PAGE_BYTES > HEADER_BYTES) ? PAGE_BYTES - HEADER_BYTES : 0;

  // page state
  logic [CNTW-1:0] slot_count, slot_count_next;
  logic [PW-1:0]   free_pointer, free_pointer_next;
  logic [PW-1:0]   free_space, free_space_next;

  // captured request
  opcode_t          op_q;
  logic [LENW-1:0]  len_q;
  logic [SLOTW-1:0] sn_q;

  // slot table: {offset, length, used}
  logic [EW-1:0] slot_table [MAX_SLOTS];
  logic [EW-1:0] rd_entry;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_addr_q;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [PW-1:0]   ent_offset;
  logic [LENW-1:0] ent_length;
  logic            ent_used;

  logic [CW-1:0]   need;
  logic [PW-1:0]   ins_offset;
  logic [SW-1:0]   sn_wide;

  status_t          st_c;
  logic [SLOTW-1:0] idx_c;
  logic [OFFW-1:0]  off_c;
  logic [LENW-1:0]  size_c;

  assign sn_wide = SW'(slot_number);
  assign rd_addr = sn_wide[IW-1:0];

  assign ent_offset = rd_entry[EW-1 -: PW];
  assign ent_length = rd_entry[LENW:1];
  assign ent_used   = rd_entry[0];

  assign need       = CW'(len_q) + CW'(SLOT_ENTRY_BYTES);
  assign ins_offset = PW'(CW'(free_pointer) - CW'(len_q));

  always_comb begin
    st_c              = ST_OK;
    idx_c             = '0;
    off_c             = '0;
    size_c            = '0;
    slot_count_next   = slot_count;
    free_pointer_next = free_pointer;
    free_space_next   = free_space;
    wr_en             = 1'b0;
    wr_addr           = slot_count[IW-1:0];
    wr_data           = {ins_offset, len_q, 1'b1};
    unique case (op_q) inside
      OP_RESET: begin
        slot_count_next   = '0;
        free_pointer_next = PW'(PAGE_BYTES);
        free_space_next   = PW'(FS0);
      end
      OP_INSERT: begin
        if (CW'(free_space) < need || slot_count >= CNTW'(MAX_SLOTS)) begin
          st_c = ST_FULL;
        end else begin
          wr_en             = 1'b1;
          idx_c             = SLOTW'(slot_count);
          off_c             = OFFW'(ins_offset);
          size_c            = len_q;
          slot_count_next   = slot_count + CNTW'(1);
          free_pointer_next = ins_offset;
          free_space_next   = PW'(CW'(free_space) - need);
        end
      end
      OP_GET, OP_DELETE: begin
        idx_c = sn_q;
        if (KW'(sn_q) >= KW'(slot_count)) begin
          st_c = ST_RANGE;
        end else if (op_q == OP_GET) begin
          if (!ent_used) begin
            st_c = ST_DELETED;
          end else begin
            off_c  = OFFW'(ent_offset);
            size_c = ent_length;
          end
        end else begin
          // clear the used mark, keep offset and length
          wr_en   = 1'b1;
          wr_addr = rd_addr_q;
          wr_data = {ent_offset, ent_length, 1'b0};
        end
      end
      default: st_c = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_entry  <= slot_table[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (cmd.commit && wr_en) begin
      slot_table[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode_t'(opcode);
      len_q <= tuple_length;
      sn_q  <= slot_number;
    end
    if (cmd.commit) begin
      status       <= st_c;
      slot_index   <= idx_c;
      tuple_offset <= off_c;
      tuple_bytes  <= size_c;
      free_bytes   <= FREEW'(free_space_next);
      slots_used   <= USEDW'(slot_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= '0;
      free_pointer <= PW'(PAGE_BYTES);
      free_space   <= PW'(FS0);
    end else if (cmd.commit) begin
      slot_count   <= slot_count_next;
      free_pointer <= free_pointer_next;
      free_space   <= free_space_next;
    end
  end

endmodule

// ----- hdl/slotted_page_allocator.sv -----
// Space manager for one slotted page: takes reset, insert, get and delete requests
// and answers each with one result carrying the status, slot, tuple offset and size,
// and the free bytes and slot count after the request. One request is in flight at a
// time: the block first captures it and reads the slot table through its registered
// read port, then evaluates it, writes the slot table and loads the result register.
// A new request is taken while the previous result still waits; the block stalls in
// the evaluate step only while that result is not yet taken. The slot table needs no
// clearing after reset, since only entries below the slot count are ever used. Tuple
// bytes are not handled: copy the payload at the returned offset.
module slotted_page_allocator import spa_pkg::*; #(
  parameter int PAGE_BYTES       = 4096,
  parameter int SLOT_ENTRY_BYTES = 8,
  parameter int HEADER_BYTES     = 16,
  parameter int MAX_SLOTS        = 512
) (
  input logic       clk,
  input logic       rst,
  spa_req_if.sink   req,
  spa_rsp_if.source rsp
);

  spa_cmd_t cmd;

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  spa_datapath #(
    .PAGE_BYTES       (PAGE_BYTES),
    .SLOT_ENTRY_BYTES (SLOT_ENTRY_BYTES),
    .HEADER_BYTES     (HEADER_BYTES),
    .MAX_SLOTS        (MAX_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .opcode       (req.opcode),
    .tuple_length (req.tuple_length),
    .slot_number  (req.slot_number),
    .status       (rsp.status),
    .slot_index   (rsp.slot_index),
    .tuple_offset (rsp.tuple_offset),
    .tuple_bytes  (rsp.tuple_bytes),
    .free_bytes   (rsp.free_bytes),
    .slots_used   (rsp.slots_used)
  );

endmodule

// ----- hdl/spa_checker.sv -----
module spa_protocol_checker import spa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [STW-1:0]   status,
  input logic [SLOTW-1:0] slot_index,
  input logic [OFFW-1:0]  tuple_offset,
  input logic [LENW-1:0]  tuple_bytes,
  input logic [FREEW-1:0] free_bytes,
  input logic [USEDW-1:0] slots_used
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // one request at a time: a taken request closes the input in the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped before taken");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> ($stable(status) && $stable(slot_index) &&
      $stable(tuple_offset) && $stable(tuple_bytes) && $stable(free_bytes) &&
      $stable(slots_used)))
    else $error("stalled result changed");

endmodule

bind slotted_page_allocator spa_protocol_checker u_spa_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .slot_index   (rsp.slot_index),
  .tuple_offset (rsp.tuple_offset),
  .tuple_bytes  (rsp.tuple_bytes),
  .free_bytes   (rsp.free_bytes),
  .slots_used   (rsp.slots_used)
);

// ----- test/spa_checker.sv -----
module spa_checker import spa_pkg::*; #(
  parameter int PAGE_BYTES       = 4096,
  parameter int SLOT_ENTRY_BYTES = 8,
  parameter int HEADER_BYTES     = 16,
  parameter int MAX_SLOTS        = 512
) (
  input  logic clk,
  input  logic rst,
  spa_req_if   req,
  spa_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t          status;
    logic [SLOTW-1:0] slot_index;
    logic [OFFW-1:0]  tuple_offset;
    logic [LENW-1:0]  tuple_bytes;
    logic [FREEW-1:0] free_bytes;
    logic [USEDW-1:0] slots_used;
  } page_answer_t;

  int unsigned  live_slots;
  int unsigned  free_ptr;
  int unsigned  slot_offset [MAX_SLOTS];
  int unsigned  slot_len    [MAX_SLOTS];
  bit           slot_live   [MAX_SLOTS];
  page_answer_t answers_due [$];
  int unsigned  results_seen;

  function automatic int unsigned gap_bytes();
    int unsigned array_end;
    array_end = HEADER_BYTES + live_slots * SLOT_ENTRY_BYTES;
    return (free_ptr > array_end) ? free_ptr - array_end : 0;
  endfunction

  // Advance the page state by one request and return the answer it must produce.
  function automatic page_answer_t apply_request(opcode_t op, int unsigned len,
                                                 int unsigned sn);
    page_answer_t a;
    a = '0;
    case (op)
      OP_RESET: begin
        live_slots = 0;
        free_ptr   = PAGE_BYTES;
      end
      OP_INSERT: begin
        if (gap_bytes() < len + SLOT_ENTRY_BYTES || live_slots >= MAX_SLOTS) begin
          a.status = ST_FULL;
        end else begin
          free_ptr                = free_ptr - len;
          slot_offset[live_slots] = free_ptr;
          slot_len[live_slots]    = len;
          slot_live[live_slots]   = 1'b1;
          a.slot_index            = SLOTW'(live_slots);
          a.tuple_offset          = OFFW'(free_ptr);
          a.tuple_bytes           = LENW'(len);
          live_slots++;
        end
      end
      default: begin
        a.slot_index = SLOTW'(sn);
        if (sn >= live_slots) begin
          a.status = ST_RANGE;
        end else if (op == OP_GET) begin
          if (!slot_live[sn]) begin
            a.status = ST_DELETED;
          end else begin
            a.tuple_offset = OFFW'(slot_offset[sn]);
            a.tuple_bytes  = LENW'(slot_len[sn]);
          end
        end else begin
          slot_live[sn] = 1'b0;
        end
      end
    endcase
    a.free_bytes = FREEW'(gap_bytes());
    a.slots_used = USEDW'(live_slots);
    return a;
  endfunction

  task automatic check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d %s: expected %0d, actual %0d",
                 results_seen, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch_channels
    page_answer_t want;
    if (rst) begin
      live_slots   = 0;
      free_ptr     = PAGE_BYTES;
      results_seen = 0;
      mismatches   = 0;
      answers_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("MISMATCH result %0d: no request waiting for it", results_seen);
        end else begin
          want = answers_due.pop_front();
          check_field("status",       16'(want.status),       16'(rsp.status));
          check_field("slot_index",   16'(want.slot_index),   16'(rsp.slot_index));
          check_field("tuple_offset", 16'(want.tuple_offset), 16'(rsp.tuple_offset));
          check_field("tuple_bytes",  16'(want.tuple_bytes),  16'(rsp.tuple_bytes));
          check_field("free_bytes",   16'(want.free_bytes),   16'(rsp.free_bytes));
          check_field("slots_used",   16'(want.slots_used),   16'(rsp.slots_used));
        end
      end
      if (req.valid && req.ready)
        answers_due.push_back(apply_request(opcode_t'(req.opcode), req.tuple_length,
                                            req.slot_number));
    end
    outstanding = answers_due.size();
  end

endmodule

// ----- test/tb_slotted_page_allocator.sv -----
module tb_slotted_page_allocator import spa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_BYTES       = 4096;
  localparam int SLOT_ENTRY_BYTES = 8;
  localparam int HEADER_BYTES     = 16;
  localparam int MAX_SLOTS        = 512;
  localparam int RANDOM_ITEMS     = 752;
  localparam int WATCHDOG_LIMIT   = 2000;

  logic clk = 1'b0;
  logic rst;
  int   req_idle_pct;
  int   rsp_stall_pct;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles = 0;

  spa_req_if req_ch ();
  spa_rsp_if rsp_ch ();

  slotted_page_allocator #(
    .PAGE_BYTES      (PAGE_BYTES),
    .SLOT_ENTRY_BYTES(SLOT_ENTRY_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_SLOTS       (MAX_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  spa_checker #(
    .PAGE_BYTES      (PAGE_BYTES),
    .SLOT_ENTRY_BYTES(SLOT_ENTRY_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_SLOTS       (MAX_SLOTS)
  ) page_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Enter and leave at a falling edge.
  task automatic send_request(opcode_t op, int unsigned len, int unsigned sn);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.tuple_length <= LENW'(len);
    req_ch.slot_number  <= SLOTW'(sn);
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly short tuples and low slot numbers, so pages fill slowly and lookups hit.
  task automatic send_random();
    int unsigned pick;
    int unsigned len;
    int unsigned sn;
    opcode_t     op;
    pick = $urandom_range(0, 99);
    op   = (pick < 2) ? OP_RESET : (pick < 50) ? OP_INSERT : (pick < 78) ? OP_GET : OP_DELETE;
    pick = $urandom_range(0, 99);
    len  = (pick < 12) ? 0 :
           (pick < 72) ? $urandom_range(1, 48) :
           (pick < 92) ? $urandom_range(0, 255) :
           (pick < 99) ? $urandom_range(0, 4096) : 4096;
    pick = $urandom_range(0, 99);
    sn   = (pick < 60) ? $urandom_range(0, 15) :
           (pick < 80) ? $urandom_range(0, 47) :
           (pick < 92) ? $urandom_range(0, 127) : $urandom_range(0, 511);
    send_request(op, len, sn);
  endtask

  initial begin
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = OP_RESET;
    req_ch.tuple_length = '0;
    req_ch.slot_number  = '0;
    rsp_ch.ready        = 1'b0;
    req_idle_pct        = 0;
    rsp_stall_pct       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(OP_GET, 0, 0);
    send_request(OP_DELETE, 0, 511);
    send_request(OP_INSERT, 0, 0);
    send_request(OP_INSERT, 4096, 0);
    send_request(OP_INSERT, 100, 0);
    send_request(OP_GET, 0, 0);
    send_request(OP_GET, 0, 1);
    send_request(OP_GET, 0, 2);
    send_request(OP_DELETE, 0, 1);
    send_request(OP_GET, 0, 1);
    send_request(OP_DELETE, 0, 1);
    // one byte too long, then exactly the remaining space
    send_request(OP_INSERT, 3957, 0);
    send_request(OP_INSERT, 3956, 0);
    send_request(OP_INSERT, 0, 0);
    send_request(OP_GET, 0, 2);
    send_request(OP_RESET, 8191, 511);
    send_request(OP_GET, 0, 0);
    send_request(OP_INSERT, 4073, 0);
    send_request(OP_INSERT, 4072, 0);
    send_request(OP_GET, 0, 0);
    send_request(OP_RESET, 0, 0);
    send_request(OP_INSERT, 4095, 0);
    send_request(OP_DELETE, 0, 256);
    send_request(OP_GET, 0, 170);

    for (int phase = 0; phase < 4; phase++) begin
      // hold new requests until the previous pacing has fully drained
      wait_drained();
      case (phase)
        0: begin
          req_idle_pct  = 0;
          rsp_stall_pct = 0;
        end
        1: begin
          req_idle_pct  = 66;
          rsp_stall_pct = 0;
        end
        2: begin
          req_idle_pct  = 0;
          rsp_stall_pct = 66;
        end
        default: begin
          req_idle_pct  = 26;
          rsp_stall_pct = 26;
        end
      endcase
      repeat (RANDOM_ITEMS / 4) send_random();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
